[design/tstb_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the tagged software timer bank
// no dependencies

package tstb_pkg;

	localparam int NUM_TIMERS  = 4;
	localparam int NUM_PRESETS = 4;
	localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam int REQ_W   = 3;
	localparam int ID_W    = 3;
	localparam int TAG_W   = 16;
	localparam int IVL_W   = 20;
	localparam int CNT_W   = 16;
	localparam int PER_W   = 8;
	localparam int MASK_W  = 4;
	localparam int STAT_W  = 2;
	localparam int CFGI_W  = 3;
	localparam int CFGD_W  = 20;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 24;

	localparam int DIV_STEPS = IVL_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam logic [TAG_W-1:0]  INVALID_TAG  = 16'hFFFF;
	localparam logic [CNT_W-1:0]  CNT_MAX      = 16'hFFFF;
	localparam logic [PER_W-1:0]  PERIOD_RESET = 8'd10;
	localparam logic [MASK_W-1:0] MASK_RESET   = 4'hF;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK         = 3'd0,
		REQ_START_PRESET = 3'd1,
		REQ_START_IVL    = 3'd2,
		REQ_CANCEL       = 3'd3,
		REQ_QUERY        = 3'd4
	} req_t;

	localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd0;
	localparam logic [STAT_W-1:0] ST_ELAPSED  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RUNNING  = 2'd2;

	localparam logic KIND_EXPIRY = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam logic [CFGI_W-1:0] CFG_TICK_PERIOD = 3'd0;
	localparam logic [CFGI_W-1:0] CFG_CB_MASK     = 3'd1;
	localparam logic [CFGI_W-1:0] CFG_PRESET0     = 3'd2;
	localparam logic [CFGI_W-1:0] CFG_PRESET1     = 3'd3;
	localparam logic [CFGI_W-1:0] CFG_PRESET2     = 3'd4;
	localparam logic [CFGI_W-1:0] CFG_PRESET3     = 3'd5;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [TAG_W-1:0] tag;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{count: '0, tag: INVALID_TAG};

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DIV      = 7'b0000010,
		S_START    = 7'b0000100,
		S_QRY      = 7'b0001000,
		S_TICK_RD  = 7'b0010000,
		S_TICK_EV  = 7'b0100000,
		S_TICK_END = 7'b1000000
	} state_t;

	function automatic logic [STAT_W-1:0] status_of(input logic [CNT_W-1:0] c);
		logic [STAT_W-1:0] s;
		if (c == '0)
			s = ST_INACTIVE;
		else if (c == CNT_W'(1))
			s = ST_ELAPSED;
		else
			s = ST_RUNNING;
		return s;
	endfunction

endpackage

[design/tagged_software_timer_bank_unit.sv]
`timescale 1ns / 1ps
// tagged one-shot timer bank: sequencer, timer entry memory, divider, output register
// depends on tstb_pkg
//
// Usage:
// Requests arrive on the s_ stream (kind in s_tuser, id/tag/interval in s_tdata);
// results leave on the m_ stream (kind in m_tuser, end of run in m_tlast).
// Timer counters and tags live in a small synchronous memory; an entry never
// written since reset reads as inactive with the all-ones tag.
// One request is processed at a time; s_tready is high while the sequencer is idle.
// Work per request, done by the sequencer and the bit-serial divider:
//   tick           one read per timer, and a write-back for each running timer
//   start          one quotient bit per cycle over the 20-bit interval, then the entry write
//   cancel         entry written while the sequencer stays idle
//   query          memory read, then the result register
//   other kinds    no action
// A finished result sits in the output register while the next request is
// taken; if m_tready stays low the sequencer waits only when it has another
// result to hand over. Reset (arst_n low) restores the register reset values,
// marks all timers inactive and empties the output register.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write them only while idle (not enforced).

module tagged_software_timer_bank_unit
	import tstb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // timer_id[2:0], corr_tag[18:3], interval_ms[38:19], zero pad
	input  logic [REQ_W-1:0]  s_tuser,  // req_type[2:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,  // which_timer[2:0], tag_out[18:3], timer_status[20:19], zero pad
	output logic [0:0]        m_tuser,  // result_kind[0]
	output logic              m_tlast,
	input  logic              cfg_we,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [CFGD_W-1:0] cfg_data
);

	// configuration
	logic [PER_W-1:0]  tick_period_q;
	logic [MASK_W-1:0] cb_mask_q;
	logic [IVL_W-1:0]  preset_q [NUM_PRESETS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= PERIOD_RESET;
			cb_mask_q     <= MASK_RESET;
			for (int i = 0; i < NUM_PRESETS; i++)
				preset_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TICK_PERIOD: tick_period_q <= cfg_data[PER_W-1:0];
				CFG_CB_MASK:     cb_mask_q     <= cfg_data[MASK_W-1:0];
				CFG_PRESET0:     preset_q[0]   <= cfg_data[IVL_W-1:0];
				CFG_PRESET1:     preset_q[1]   <= cfg_data[IVL_W-1:0];
				CFG_PRESET2:     preset_q[2]   <= cfg_data[IVL_W-1:0];
				CFG_PRESET3:     preset_q[3]   <= cfg_data[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [ID_W-1:0]  in_id;
	logic [TAG_W-1:0] in_tag;
	logic [IVL_W-1:0] in_ivl;
	req_t             in_req;
	logic             in_id_ok;
	logic             acc;

	assign in_id    = s_tdata[2:0];
	assign in_tag   = s_tdata[18:3];
	assign in_ivl   = s_tdata[38:19];
	assign in_req   = req_t'(s_tuser);
	assign in_id_ok = in_id < ID_W'(NUM_TIMERS);

	// sequencer and payload registers
	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              qvld_q;
	logic              pend_q;
	logic [ID_W-1:0]   id_q;
	logic [TAG_W-1:0]  tag_q;
	logic [IVL_W-1:0]  quo_q;
	logic [PER_W-1:0]  rem_q;
	logic [PER_W-1:0]  dvs_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [TAG_W-1:0]  pend_tag_q;

	// timer entry memory
	entry_t            mem [NUM_TIMERS];
	entry_t            rd_s1;
	logic              rvld_s1;
	logic [NUM_TIMERS-1:0] vld_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	entry_t            mem_wd;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_ra;
	entry_t            eff;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_s1 <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (mem_we)
				vld_q[mem_wa] <= 1'b1;
			if (mem_re)
				rvld_s1 <= vld_q[mem_ra];
		end
	end

	assign eff = rvld_s1 ? rd_s1 : ENTRY_RESET;

	// output register
	logic              m_tvalid_q;
	logic              out_free;
	logic              push;
	logic              push_kind;
	logic [ID_W-1:0]   push_id;
	logic [TAG_W-1:0]  push_tag;
	logic [STAT_W-1:0] push_stat;
	logic              push_last;
	logic [ID_W-1:0]   out_id_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [STAT_W-1:0] out_stat_q;
	logic              out_kind_q;
	logic              out_last_q;

	assign out_free = !m_tvalid_q || m_tready;

	// tick evaluation
	logic             running;
	logic [CNT_W-1:0] newc;
	logic             expire;
	logic             tick_adv;
	logic             last_idx;

	assign running  = eff.count > CNT_W'(1);
	assign newc     = eff.count - CNT_W'(1);
	assign expire   = running && (newc == CNT_W'(1)) && cb_mask_q[idx_q];
	assign tick_adv = !(expire && pend_q) || out_free;
	assign last_idx = idx_q == IDX_W'(NUM_TIMERS - 1);

	// divider step and count saturation
	logic [PER_W:0]   rem_sh;
	logic [PER_W:0]   rem_diff;
	logic             q_bit;
	logic [CNT_W-1:0] load_cnt;

	assign rem_sh   = {rem_q, quo_q[IVL_W-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign q_bit    = rem_sh >= {1'b0, dvs_q};
	assign load_cnt = ((quo_q[IVL_W-1:CNT_W] != '0) || (quo_q[CNT_W-1:0] == CNT_MAX))
		? CNT_MAX : quo_q[CNT_W-1:0] + CNT_W'(1);

	assign s_tready = state_q == S_IDLE;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		mem_we    = 1'b0;
		mem_wa    = idx_q;
		mem_wd    = ENTRY_RESET;
		mem_re    = 1'b0;
		mem_ra    = idx_q;
		push      = 1'b0;
		push_kind = KIND_EXPIRY;
		push_id   = pend_id_q;
		push_tag  = pend_tag_q;
		push_stat = ST_ELAPSED;
		push_last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && in_id_ok && in_req == REQ_CANCEL) begin
					mem_we = 1'b1;
					mem_wa = in_id[IDX_W-1:0];
				end
				if (acc && in_id_ok && in_req == REQ_QUERY) begin
					mem_re = 1'b1;
					mem_ra = in_id[IDX_W-1:0];
				end
			end
			S_START: begin
				mem_we = 1'b1;
				mem_wa = id_q[IDX_W-1:0];
				mem_wd = '{count: load_cnt, tag: tag_q};
			end
			S_QRY: begin
				push      = out_free;
				push_kind = KIND_QUERY;
				push_id   = id_q;
				push_tag  = qvld_q ? eff.tag : '0;
				push_stat = qvld_q ? status_of(eff.count) : ST_INACTIVE;
				push_last = 1'b1;
			end
			S_TICK_RD: begin
				mem_re = 1'b1;
			end
			S_TICK_EV: begin
				if (tick_adv && running) begin
					mem_we = 1'b1;
					mem_wd = '{count: newc, tag: eff.tag};
				end
				push = tick_adv && expire && pend_q;
			end
			S_TICK_END: begin
				push      = pend_q && out_free;
				push_last = 1'b1;
			end
			S_DIV: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			dcnt_q  <= '0;
			qvld_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (in_req)
							REQ_TICK: begin
								idx_q   <= '0;
								state_q <= S_TICK_RD;
							end
							REQ_START_PRESET, REQ_START_IVL: begin
								dcnt_q <= '0;
								if (in_id_ok)
									state_q <= S_DIV;
							end
							REQ_QUERY: begin
								qvld_q  <= in_id_ok;
								state_q <= S_QRY;
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(DIV_STEPS - 1))
						state_q <= S_START;
				end
				S_START:   state_q <= S_IDLE;
				S_QRY: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				S_TICK_RD: state_q <= S_TICK_EV;
				S_TICK_EV: begin
					if (tick_adv) begin
						if (expire)
							pend_q <= 1'b1;
						if (last_idx) begin
							state_q <= S_TICK_END;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_TICK_RD;
						end
					end
				end
				S_TICK_END: begin
					if (!pend_q || out_free) begin
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			id_q  <= in_id;
			tag_q <= in_tag;
			rem_q <= '0;
			dvs_q <= (tick_period_q == '0) ? PER_W'(1) : tick_period_q;
			quo_q <= (in_req == REQ_START_PRESET) ? preset_q[in_id[1:0]] : in_ivl;
		end else if (state_q == S_DIV) begin
			rem_q <= q_bit ? rem_diff[PER_W-1:0] : rem_sh[PER_W-1:0];
			quo_q <= {quo_q[IVL_W-2:0], q_bit};
		end
		if (state_q == S_TICK_EV && tick_adv && expire) begin
			pend_id_q  <= ID_W'(idx_q);
			pend_tag_q <= eff.tag;
		end
		if (push) begin
			out_kind_q <= push_kind;
			out_id_q   <= push_id;
			out_tag_q  <= push_tag;
			out_stat_q <= push_stat;
			out_last_q <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (push)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_stat_q, out_tag_q, out_id_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// checks
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("memory read and write in the same cycle");

	a_pend_only_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DIV || state_q == S_START || state_q == S_QRY)
		|-> !pend_q)
		else $error("pending expiry outside a tick walk");

	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QRY && out_free)
		|=> (m_tvalid && m_tlast && m_tuser == KIND_QUERY))
		else $error("query did not produce a final query result");

	a_expiry_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_EXPIRY) |-> (out_stat_q == ST_ELAPSED))
		else $error("expiry result without elapsed status");

	a_no_push_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed over an untaken result");

endmodule

[dv/timer_bank_checker.sv]
`timescale 1ns / 1ps
// checker for the tagged software timer bank: watches request, result and register
// write ports, keeps its own copy of the timer state and compares every result
// depends on tstb_pkg

module timer_bank_checker
	import tstb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // timer_id[2:0], corr_tag[18:3], interval_ms[38:19], zero pad
	input  logic [REQ_W-1:0]  s_tuser,  // req_type[2:0]
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [OUT_W-1:0]  m_tdata,  // which_timer[2:0], tag_out[18:3], timer_status[20:19], zero pad
	input  logic [0:0]        m_tuser,  // result_kind[0]
	input  logic              m_tlast,
	input  logic              cfg_we,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [CFGD_W-1:0] cfg_data,
	output int                fail_count,
	output int                pending
);

	typedef struct {
		logic              kind;
		logic [ID_W-1:0]   timer;
		logic [TAG_W-1:0]  tag;
		logic [STAT_W-1:0] status;
		logic              last;
	} timer_event_t;

	timer_event_t      owed_events[$];

	logic [PER_W-1:0]  tick_period;
	logic [MASK_W-1:0] cb_mask;
	logic [IVL_W-1:0]  preset_ms [NUM_PRESETS];
	logic [CNT_W-1:0]  ticks_left [NUM_TIMERS];
	logic [TAG_W-1:0]  timer_tag [NUM_TIMERS];

	function automatic logic [CNT_W-1:0] ticks_for(input logic [IVL_W-1:0] ms);
		int unsigned divisor;
		int unsigned n;
		divisor = (tick_period == '0) ? 1 : tick_period;
		n = ms / divisor + 1;
		return (n > CNT_MAX) ? CNT_MAX : CNT_W'(n);
	endfunction

	task automatic apply_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
			input logic [TAG_W-1:0] tag, input logic [IVL_W-1:0] ivl);
		int                first;
		logic              known_id;
		logic [IDX_W-1:0]  slot;
		logic [STAT_W-1:0] status;
		timer_event_t      ev;
		first    = owed_events.size();
		known_id = id < NUM_TIMERS;
		slot     = id[IDX_W-1:0];
		case (req)
			REQ_TICK: begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (ticks_left[i] > 1) begin
						ticks_left[i] = ticks_left[i] - 1'b1;
						if (ticks_left[i] == 1 && cb_mask[i]) begin
							ev = '{KIND_EXPIRY, ID_W'(i), timer_tag[i], ST_ELAPSED, 1'b0};
							owed_events.push_back(ev);
						end
					end
				end
			end
			REQ_START_PRESET, REQ_START_IVL: begin
				if (known_id) begin
					ticks_left[slot] = ticks_for(req == REQ_START_PRESET ? preset_ms[slot] : ivl);
					timer_tag[slot]  = tag;
				end
			end
			REQ_CANCEL: begin
				if (known_id) begin
					ticks_left[slot] = '0;
					timer_tag[slot]  = INVALID_TAG;
				end
			end
			REQ_QUERY: begin
				if (known_id) begin
					if (ticks_left[slot] > 1)
						status = ST_RUNNING;
					else if (ticks_left[slot] == 1)
						status = ST_ELAPSED;
					else
						status = ST_INACTIVE;
					ev = '{KIND_QUERY, id, timer_tag[slot], status, 1'b0};
				end else
					ev = '{KIND_QUERY, id, '0, ST_INACTIVE, 1'b0};
				owed_events.push_back(ev);
			end
			default: ;
		endcase
		if (owed_events.size() > first) begin
			ev = owed_events.pop_back();
			ev.last = 1'b1;
			owed_events.push_back(ev);
		end
	endtask

	function automatic int field_differs(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin
		timer_event_t got;
		timer_event_t want;
		if (!arst_n) begin
			tick_period = PERIOD_RESET;
			cb_mask     = MASK_RESET;
			for (int i = 0; i < NUM_PRESETS; i++)
				preset_ms[i] = '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				ticks_left[i] = '0;
				timer_tag[i]  = INVALID_TAG;
			end
			owed_events.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TICK_PERIOD: tick_period  = cfg_data[PER_W-1:0];
					CFG_CB_MASK:     cb_mask      = cfg_data[MASK_W-1:0];
					CFG_PRESET0:     preset_ms[0] = cfg_data[IVL_W-1:0];
					CFG_PRESET1:     preset_ms[1] = cfg_data[IVL_W-1:0];
					CFG_PRESET2:     preset_ms[2] = cfg_data[IVL_W-1:0];
					CFG_PRESET3:     preset_ms[3] = cfg_data[IVL_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				apply_request(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W +: TAG_W],
					s_tdata[ID_W+TAG_W +: IVL_W]);
			if (m_tvalid && m_tready) begin
				got = '{m_tuser[0], m_tdata[ID_W-1:0], m_tdata[ID_W +: TAG_W],
					m_tdata[ID_W+TAG_W +: STAT_W], m_tlast};
				if (owed_events.size() == 0) begin
					$error("unexpected transaction: kind %0d timer %0d tag %0h status %0d",
						got.kind, got.timer, got.tag, got.status);
					fail_count++;
				end else begin
					want = owed_events.pop_front();
					fail_count += field_differs("result_kind", want.kind, got.kind);
					fail_count += field_differs("which_timer", want.timer, got.timer);
					fail_count += field_differs("tag_out", want.tag, got.tag);
					fail_count += field_differs("timer_status", want.status, got.status);
					fail_count += field_differs("last_of_run", want.last, got.last);
				end
			end
		end
		pending = owed_events.size();
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// top of the timer bank testbench: clock, reset, request and register stimulus,
// result back-pressure and the verdict; depends on tstb_pkg, the unit and timer_bank_checker

module tb_top
	import tstb_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASES         = 5;
	localparam int PHASE_ITEMS    = 15;
	localparam int ID_TOP         = (1 << ID_W) - 1;
	localparam logic [REQ_W-1:0]  REQ_SPARE_LO = 3'd5;
	localparam logic [REQ_W-1:0]  REQ_SPARE_HI = 3'd7;
	localparam logic [CFGI_W-1:0] CFG_SPARE    = 3'd6;
	localparam logic [CFGI_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic [IVL_W-1:0]  IVL_MAX      = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;   // timer_id[2:0], corr_tag[18:3], interval_ms[38:19], zero pad
	logic [REQ_W-1:0]  s_tuser = '0;   // req_type[2:0]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;        // which_timer[2:0], tag_out[18:3], timer_status[20:19], zero pad
	logic [0:0]        m_tuser;        // result_kind[0]
	logic              m_tlast;
	logic              cfg_we = 1'b0;
	logic [CFGI_W-1:0] cfg_index = '0;
	logic [CFGD_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	bit idling = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	tagged_software_timer_bank_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	timer_bank_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// result back-pressure in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			stall_left = int'($urandom_range(0, 14));
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
			input logic [TAG_W-1:0] tag, input logic [IVL_W-1:0] ivl);
		if (idling && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {1'b0, ivl, tag, id};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// drain all results, then give a start or tick with no result time to finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_config(input logic [PER_W-1:0] period, input logic [MASK_W-1:0] mask,
			input logic [IVL_W-1:0] p0, input logic [IVL_W-1:0] p1,
			input logic [IVL_W-1:0] p2, input logic [IVL_W-1:0] p3);
		logic [CFGD_W-1:0] vals [7];
		vals[CFG_TICK_PERIOD] = CFGD_W'(period);
		vals[CFG_CB_MASK]     = CFGD_W'(mask);
		vals[CFG_PRESET0]     = p0;
		vals[CFG_PRESET1]     = p1;
		vals[CFG_PRESET2]     = p2;
		vals[CFG_PRESET3]     = p3;
		vals[CFG_SPARE]       = CFGD_W'($urandom);
		for (int k = 0; k <= CFG_SPARE; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= (k == CFG_SPARE && $urandom_range(0, 1)) ? CFG_SPARE_HI : CFGI_W'(k);
			cfg_data  <= vals[k];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [PER_W-1:0]  period;
		logic [MASK_W-1:0] mask;
		logic [IVL_W-1:0]  presets [NUM_PRESETS];
		logic [REQ_W-1:0]  req;
		logic [ID_W-1:0]   id;
		logic [TAG_W-1:0]  tag;
		logic [IVL_W-1:0]  ivl;
		int                eff_period;
		int                roll;
		int                counted;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset state: period 10, all timers inactive
		send_request(REQ_QUERY, 3'd0, '0, '0);
		send_request(REQ_QUERY, 3'd7, 16'h5A5A, IVL_MAX);
		send_request(REQ_START_PRESET, 3'd0, 16'h0000, '0);
		send_request(REQ_START_IVL, 3'd1, 16'hFFFF, 20'd25);
		send_request(REQ_START_IVL, 3'd2, 16'h1234, IVL_MAX);
		send_request(REQ_START_IVL, 3'd3, 16'hABCD, 20'd9);
		send_request(REQ_START_IVL, 3'd5, 16'h1111, 20'd30);
		send_request(REQ_CANCEL, 3'd6, 16'h2222, '0);
		send_request(REQ_START_PRESET, 3'd4, 16'h3333, '0);
		send_request(REQ_QUERY, 3'd3, '0, '0);
		send_request(REQ_TICK, 3'd7, 16'hFFFF, IVL_MAX);
		send_request(REQ_TICK, 3'd0, '0, '0);
		send_request(REQ_QUERY, 3'd2, '0, '0);
		send_request(REQ_CANCEL, 3'd2, '0, '0);
		send_request(REQ_QUERY, 3'd2, '0, '0);
		send_request(REQ_SPARE_LO, 3'd1, 16'h4444, 20'd5);
		send_request(REQ_SPARE_HI, 3'd2, 16'h5555, 20'd5);
		send_request(REQ_TICK, 3'd0, '0, '0);

		// zero period acts as one; all four timers expire on the same tick
		settle();
		write_config('0, 4'hF, 20'd1, 20'd1, 20'd1, 20'd1);
		for (int i = 0; i < NUM_TIMERS; i++)
			send_request(REQ_START_PRESET, ID_W'(i), TAG_W'($urandom), '0);
		send_request(REQ_TICK, '0, '0, '0);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: period = 8'd1;
				1: period = 8'd255;
				3: period = '0;
				default: period = PER_W'($urandom_range(1, 255));
			endcase
			eff_period = (period == '0) ? 1 : period;
			case (phase)
				1, 4: mask = 4'hF;
				2: mask = '0;
				default: mask = MASK_W'($urandom);
			endcase
			for (int i = 0; i < NUM_PRESETS; i++)
				presets[i] = (phase == 2) ? '0 : IVL_W'($urandom_range(0, eff_period * 8));
			if (phase == 1)
				presets[NUM_PRESETS-1] = IVL_MAX;
			write_config(period, mask, presets[0], presets[1], presets[2], presets[3]);
			if (phase == PHASES - 1)
				idling = 1'b0;

			counted = 0;
			while (counted < PHASE_ITEMS) begin
				roll = int'($urandom_range(0, 99));
				if ($urandom_range(0, 9) == 0)
					id = ID_W'($urandom_range(NUM_TIMERS, ID_TOP));
				else
					id = ID_W'($urandom_range(0, NUM_TIMERS - 1));
				tag = TAG_W'($urandom);
				if ($urandom_range(0, 15) == 0)
					ivl = IVL_W'($urandom);
				else
					ivl = IVL_W'($urandom_range(0, eff_period * 6));
				if (roll < 35)
					req = REQ_TICK;
				else if (roll < 50)
					req = REQ_START_PRESET;
				else if (roll < 68)
					req = REQ_START_IVL;
				else if (roll < 76)
					req = REQ_CANCEL;
				else if (roll < 95)
					req = REQ_QUERY;
				else
					req = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
				send_request(req, id, tag, ivl);
				if (req == REQ_TICK || req == REQ_QUERY || (req <= REQ_CANCEL && id < NUM_TIMERS))
					counted++;
			end
		end

		settle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
design/tstb_pkg.sv
design/tagged_software_timer_bank_unit.sv
dv/timer_bank_checker.sv
dv/tb_top.sv
